>>> rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

   // Default table size and time width
   localparam int MAX_ENTRIES_DEF = 32;
   localparam int TIME_BITS_DEF   = 48;

   // Fixed field widths of the transactions
   localparam int NOW_PORT_W = 48;
   localparam int DELAY_IN_W = 32;
   localparam int DELAY_W    = 49;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Operation codes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_EXPIRE = 1'b1;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_OK      = 2'd0,
      KIND_INVALID = 2'd1,
      KIND_FULL    = 2'd2,
      KIND_FIRED   = 2'd3
   } kind_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STATUS
   } back_state_type;

   // Request transaction
   typedef struct packed {
      logic                  opcode;
      logic [7:0]            task_handle;
      logic [DELAY_IN_W-1:0] wait_ms;
      logic [NOW_PORT_W-1:0] now_ms;
   } req_type;

   // Result transaction
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         fired_handle;
      logic [DELAY_W-1:0] next_delay_ms;
      logic               timer_armed;
      logic               last;
   } rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      req_type req;
      logic    invalid;
   } cmd_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

endpackage

>>> rtl/dtt_ram.sv
// ----------------------------------------------------------------------------
// dtt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dtt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dtt_front.sv
// ----------------------------------------------------------------------------
// dtt_front
// Accepts request transactions, flags invalid adds and queues commands.
// ----------------------------------------------------------------------------
module dtt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  dtt_pkg::req_type     req_data,
   output logic                 busy,
   output dtt_pkg::cmd_head_type head,
   input  logic                 cmd_pop
);
   import dtt_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [QW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           push;
   cmd_type        new_cmd;

   // Classify: zero handle or zero delay on an add is rejected
   always_comb begin
      new_cmd.req     = req_data;
      new_cmd.invalid = (req_data.opcode == OP_ADD) &&
                        ((req_data.task_handle == '0) || (req_data.wait_ms == '0));
   end

   assign busy = (fill_ff == FW'(QUEUE_DEPTH));
   assign push = start && !busy;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

endmodule

>>> rtl/dtt_back.sv
// ----------------------------------------------------------------------------
// dtt_back
// Executes queued commands against the timeout table and emits results.
// ----------------------------------------------------------------------------
module dtt_back #(
   parameter int MAX_ENTRIES = dtt_pkg::MAX_ENTRIES_DEF,
   parameter int TIME_BITS   = dtt_pkg::TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtt_pkg::cmd_head_type head,
   output logic                  cmd_pop,
   output logic                  rsp_strobe,
   output dtt_pkg::rsp_type      rsp_data
);
   import dtt_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int NOW_W = (TIME_BITS < NOW_PORT_W) ? TIME_BITS : NOW_PORT_W;
   localparam int DL_W  = ((TIME_BITS > DELAY_IN_W) ? TIME_BITS : DELAY_IN_W) + 1;
   localparam int WIDE  = (DL_W > DELAY_W) ? DL_W : DELAY_W;
   localparam int ENT_W = DL_W + 8;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic             eval_valid_ff, eval_valid_in;
   logic [DL_W-1:0]  min_ff, min_in;
   logic [DL_W-1:0]  now_ff, now_in;
   kind_type         kind_ff, kind_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic [ENT_W-1:0] rd_data;
   logic [DL_W-1:0]  rd_deadline;
   logic [7:0]       rd_handle;
   logic [DL_W-1:0]  cmd_now;
   logic [DL_W-1:0]  cmd_deadline;
   logic [DL_W-1:0]  diff;
   logic [WIDE-1:0]  diff_wide;

   // Entry store: handle above deadline
   dtt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ENTRIES),
      .ADDR_W(IDX_W)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_idx_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   assign rd_deadline = rd_data[DL_W-1:0];
   assign rd_handle   = rd_data[ENT_W-1:DL_W];

   // Deadline of an add, current time truncated to the time width
   assign cmd_now      = DL_W'(head.cmd.req.now_ms[NOW_W-1:0]);
   assign cmd_deadline = cmd_now + DL_W'(head.cmd.req.wait_ms);

   // Delay to the earliest deadline, at least one
   assign diff      = (min_ff > now_ff) ? (min_ff - now_ff) : DL_W'(1);
   assign diff_wide = WIDE'(diff);

   // Sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      keep_in       = keep_ff;
      eval_valid_in = 1'b0;
      min_in        = min_ff;
      now_in        = now_ff;
      kind_in       = kind_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = {head.cmd.req.task_handle, cmd_deadline};

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               cmd_pop = 1'b1;
               now_in  = cmd_now;
               if (head.cmd.req.opcode == OP_ADD) begin
                  state_in = ST_STATUS;
                  if (head.cmd.invalid) begin
                     kind_in = KIND_INVALID;
                  end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                     kind_in = KIND_FULL;
                  end else begin
                     kind_in  = KIND_OK;
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if ((count_ff == '0) || (cmd_deadline < min_ff)) begin
                        min_in = cmd_deadline;
                     end
                  end
               end else begin
                  kind_in   = KIND_OK;
                  rd_idx_in = '0;
                  keep_in   = '0;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue the next read
            if (rd_idx_ff < count_ff) begin
               eval_valid_in = 1'b1;
               rd_idx_in     = rd_idx_ff + 1'b1;
            end
            // Fire or compact the entry read last cycle
            if (eval_valid_ff) begin
               if (now_ff >= rd_deadline) begin
                  rsp_strobe_in             = 1'b1;
                  rsp_data_in.kind          = KIND_FIRED;
                  rsp_data_in.fired_handle  = rd_handle;
                  rsp_data_in.next_delay_ms = '0;
                  rsp_data_in.timer_armed   = 1'b0;
                  rsp_data_in.last          = 1'b0;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = keep_ff[IDX_W-1:0];
                  wr_data = rd_data;
                  keep_in = keep_ff + 1'b1;
                  if ((keep_ff == '0) || (rd_deadline < min_ff)) begin
                     min_in = rd_deadline;
                  end
               end
            end
            // All entries issued: the last one is evaluated now
            if (rd_idx_ff == count_ff) begin
               count_in = keep_in;
               state_in = ST_STATUS;
            end
         end

         ST_STATUS: begin
            rsp_strobe_in            = 1'b1;
            rsp_data_in.kind         = kind_ff;
            rsp_data_in.fired_handle = '0;
            rsp_data_in.timer_armed  = (count_ff != '0);
            rsp_data_in.last         = 1'b1;
            rsp_data_in.next_delay_ms = (count_ff != '0) ? diff_wide[DELAY_W-1:0] : '0;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         keep_ff       <= '0;
         eval_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         keep_ff       <= keep_in;
         eval_valid_ff <= eval_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      min_ff      <= min_in;
      now_ff      <= now_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> rtl/deadline_timer_table_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_core
// Table of pending timeouts with earliest-deadline status reporting.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken when start is high and busy is low. An add
//   (opcode 0) stores now_ms + wait_ms under task_handle; an expire (opcode 1)
//   fires every entry whose deadline has passed, one kind 3 result each in
//   table order, and compacts the rest.
//   Every transaction ends with one status result (last = 1) carrying the delay
//   to the earliest pending deadline and the armed flag.
//   Results appear on rsp_data for one cycle, marked by rsp_strobe; the
//   receiver cannot stall them.
//   With an idle back end, an add is popped from the queue and gives its
//   registered status result from the status state. An expire steps through
//   the scan state, bound by one table RAM read per cycle, and then gives its
//   status, so it takes longer as the table fills.
//   A two-entry command queue lets up to two requests wait while one executes;
//   busy is high while the queue is full.
//   Reset empties the table and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module deadline_timer_table_core #(
   parameter int MAX_ENTRIES = dtt_pkg::MAX_ENTRIES_DEF,
   parameter int TIME_BITS   = dtt_pkg::TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dtt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dtt_pkg::rsp_type rsp_data
);
   import dtt_pkg::*;

   cmd_head_type head;
   logic         cmd_pop;

   // Front: accept, classify and queue
   dtt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_data(req_data),
      .busy    (busy),
      .head    (head),
      .cmd_pop (cmd_pop)
   );

   // Back: table execution and results
   dtt_back #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .TIME_BITS  (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .cmd_pop   (cmd_pop),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // Back end only takes a command that is queued
   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> head.valid)
      else $error("command popped from empty queue");

   // Only fired results are non-final
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> rsp_data.kind == KIND_FIRED)
      else $error("non-final result is not a fired task");

   // An armed status always reports a nonzero delay
   a_armed_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last && rsp_data.timer_armed |->
         rsp_data.next_delay_ms != '0)
      else $error("armed status with zero delay");

   // A final result never follows a final result directly
   a_status_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !(rsp_strobe && rsp_data.last))
      else $error("back-to-back status results");

endmodule

>>> sim/deadline_timer_table_core_test.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_core_test
// Self-checking bench for the deadline timer table core.
// A directed opening covers empty, invalid, wide-deadline and boundary cases.
// Random add bursts, expiry events, table fills, sweeps and full-range noise
// follow. A scoreboard keeps its own copy of the table, predicts every result
// of each accepted request and compares the results in arrival order.
// ----------------------------------------------------------------------------
module deadline_timer_table_core_test;
   import dtt_pkg::*;

   localparam int ITEM_TARGET  = 360;
   localparam int MISMATCH_LOG = 10;

   // Shadow of the timer table and queue of predicted results
   class timer_table_board;
      logic [DELAY_W-1:0] deadline_at [MAX_ENTRIES_DEF];
      logic [7:0]         handle_at   [MAX_ENTRIES_DEF];
      int unsigned        entry_count;
      rsp_type            due_results [$];
      int unsigned        mismatch_count;
      int unsigned        adds_taken, expires_taken;
      int unsigned        invalid_count, full_count, fired_count, peak_count;

      // Status result: delay to the earliest pending deadline, at least 1
      function rsp_type status_result(kind_type kind, logic [NOW_PORT_W-1:0] now);
         rsp_type            stat;
         logic [DELAY_W-1:0] earliest;
         logic [DELAY_W-1:0] now_wide;
         int unsigned        i;
         stat      = '0;
         stat.kind = kind;
         stat.last = 1'b1;
         now_wide  = DELAY_W'(now);
         if (entry_count != 0) begin
            earliest = deadline_at[0];
            for (i = 1; i < entry_count; i++)
               if (deadline_at[i] < earliest) earliest = deadline_at[i];
            stat.timer_armed   = 1'b1;
            stat.next_delay_ms = (earliest > now_wide) ? earliest - now_wide
                                                       : DELAY_W'(1);
         end
         return stat;
      endfunction

      // Predict the results of one accepted request
      function void note_request(req_type item);
         rsp_type            fired;
         logic [DELAY_W-1:0] now_wide;
         int unsigned        i, keep;
         now_wide = DELAY_W'(item.now_ms);
         if (item.opcode == OP_ADD) begin
            adds_taken++;
            if (item.task_handle == 8'd0 || item.wait_ms == '0) begin
               invalid_count++;
               due_results.push_back(status_result(KIND_INVALID, item.now_ms));
            end else if (entry_count >= MAX_ENTRIES_DEF) begin
               full_count++;
               due_results.push_back(status_result(KIND_FULL, item.now_ms));
            end else begin
               deadline_at[entry_count] = now_wide + DELAY_W'(item.wait_ms);
               handle_at[entry_count]   = item.task_handle;
               entry_count++;
               if (entry_count > peak_count) peak_count = entry_count;
               due_results.push_back(status_result(KIND_OK, item.now_ms));
            end
         end else begin
            expires_taken++;
            keep = 0;
            // fire due entries in table order, compact the rest
            for (i = 0; i < entry_count; i++) begin
               if (now_wide >= deadline_at[i]) begin
                  fired              = '0;
                  fired.kind         = KIND_FIRED;
                  fired.fired_handle = handle_at[i];
                  due_results.push_back(fired);
                  fired_count++;
               end else begin
                  deadline_at[keep] = deadline_at[i];
                  handle_at[keep]   = handle_at[i];
                  keep++;
               end
            end
            entry_count = keep;
            due_results.push_back(status_result(KIND_OK, item.now_ms));
         end
      endfunction

      // Compare one result with the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_LOG)
               $display("unexpected result: kind %0d handle %0d delay %0d armed %b last %b",
                        got.kind, got.fired_handle, got.next_delay_ms,
                        got.timer_armed, got.last);
            return;
         end
         want = due_results.pop_front();
         if (got.kind !== want.kind || got.fired_handle !== want.fired_handle ||
             got.next_delay_ms !== want.next_delay_ms ||
             got.timer_armed !== want.timer_armed || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_LOG) begin
               $display("mismatch at %0t: expected kind %0d handle %0d delay %0d armed %b last %b",
                        $realtime, want.kind, want.fired_handle, want.next_delay_ms,
                        want.timer_armed, want.last);
               $display("                 got      kind %0d handle %0d delay %0d armed %b last %b",
                        got.kind, got.fired_handle, got.next_delay_ms,
                        got.timer_armed, got.last);
            end
         end
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   timer_table_board board = new();

   int unsigned            items_sent      = 0;
   int unsigned            sender_idle_pct = 20;
   logic [NOW_PORT_W-1:0]  clock_ms        = '0;

   deadline_timer_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) board.check_result(rsp_data);
   end

   // Drive one request transaction, with random idle cycles ahead of it
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(item);
      items_sent++;
   endtask

   task automatic add_timer(input logic [7:0] handle, input logic [DELAY_IN_W-1:0] delay,
                            input logic [NOW_PORT_W-1:0] now);
      req_type item;
      item.opcode      = OP_ADD;
      item.task_handle = handle;
      item.wait_ms     = delay;
      item.now_ms      = now;
      send_item(item);
   endtask

   // Expiry event; handle and delay are don't-care, so they carry noise
   task automatic expire_at(input logic [NOW_PORT_W-1:0] now);
      req_type item;
      item.opcode      = OP_EXPIRE;
      item.task_handle = 8'($urandom_range(255));
      item.wait_ms     = $urandom;
      item.now_ms      = now;
      send_item(item);
   endtask

   // Hold off new requests until every predicted result has arrived
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [NOW_PORT_W-1:0] random_time();
      logic [31:0] upper, lower;
      upper = $urandom;
      lower = $urandom;
      return {upper[15:0], lower};
   endfunction

   // Fill the table past capacity, some adds invalid, then expire part of it
   task automatic fill_table();
      int unsigned n, i;
      n = MAX_ENTRIES_DEF - board.entry_count + $urandom_range(2, 8);
      for (i = 0; i < n; i++) begin
         clock_ms += NOW_PORT_W'($urandom_range(0, 3));
         case ($urandom_range(9))
            0:       add_timer(8'd0, $urandom_range(1, 1000), clock_ms);
            1:       add_timer(8'($urandom_range(1, 255)), '0, clock_ms);
            default: add_timer(8'($urandom_range(1, 255)), $urandom_range(1, 1000),
                               clock_ms);
         endcase
      end
      clock_ms += NOW_PORT_W'($urandom_range(0, 600));
      expire_at(clock_ms);
   endtask

   // One random episode of well-formed traffic or noise
   task automatic run_episode();
      req_type     item;
      int unsigned pick, n, i;
      pick = $urandom_range(99);
      if (pick < 6) begin
         fill_table();
      end else if (pick < 40) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++) begin
            clock_ms += NOW_PORT_W'($urandom_range(0, 5));
            if ($urandom_range(19) == 0)
               add_timer(8'd0, $urandom_range(0, 500), clock_ms);
            else
               add_timer(8'($urandom_range(1, 255)), $urandom_range(1, 500), clock_ms);
         end
      end else if (pick < 70) begin
         clock_ms += NOW_PORT_W'($urandom_range(0, 400));
         expire_at(clock_ms);
      end else if (pick < 75) begin
         expire_at(clock_ms);
      end else if (pick < 87) begin
         item.opcode      = 1'($urandom_range(1));
         item.task_handle = 8'($urandom_range(255));
         item.wait_ms     = ($urandom_range(7) == 0) ? '0 : $urandom;
         item.now_ms      = random_time();
         send_item(item);
      end else if (pick < 92) begin
         // sweep: fire everything reachable, then jump the time base
         expire_at('1);
         clock_ms = NOW_PORT_W'($urandom);
      end else begin
         add_timer(8'($urandom_range(1, 255)), $urandom, clock_ms);
      end
   endtask

   // Directed opening
   task automatic run_directed();
      expire_at('0);
      add_timer(8'd0, 32'd5, '0);
      add_timer(8'd7, '0, '0);
      add_timer(8'd0, '0, '0);
      // deadline past the time range: never fires, next delay uses bit 48
      add_timer(8'hFF, '1, '1);
      expire_at('0);
      expire_at('1);
      add_timer(8'h01, 32'd1, 48'd100);
      add_timer(8'h80, 32'd3, 48'd100);
      add_timer(8'h55, 32'd2, 48'd100);
      // fires exactly at its deadline
      expire_at(48'd101);
      // earliest deadline already passed: next delay is 1
      add_timer(8'hAA, 32'd50, 48'd200);
      expire_at(48'd300);
      add_timer(8'h42, 32'h8000_0000, 48'h8000_0000_0000);
      expire_at(48'h7FFF_FFFF_FFFF);
      expire_at(48'h8000_8000_0000);
   endtask

   initial begin
      int unsigned want_pct;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain();
      fill_table();
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 240)      want_pct = 0;
         else if (items_sent >= 120) want_pct = 47;
         else                        want_pct = 20;
         if (want_pct != sender_idle_pct) begin
            drain();
            sender_idle_pct = want_pct;
         end
         run_episode();
      end
      drain();
      repeat (MAX_ENTRIES_DEF + 8) @(posedge clock);
      $display("run covered %0d adds (%0d invalid, %0d refused as full) and %0d expiry events",
               board.adds_taken, board.invalid_count, board.full_count, board.expires_taken);
      $display("%0d timers fired, table peaked at %0d entries, %0d mismatches",
               board.fired_count, board.peak_count, board.mismatch_count);
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
